>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/knd_pkg.sv
// ----------------------------------------------------------------------------
// knd_pkg
// Shared types and constants of the k-th nearest distance query unit.
// ----------------------------------------------------------------------------
package knd_pkg;

	localparam int COORD_W = 32;
	localparam int DIST_W  = 32;
	localparam int RANK_W  = 9;
	localparam int STAT_W  = 2;
	localparam int BIT_W   = $clog2(DIST_W);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_DONE
	} fsm_state_t;

	// Broadcast to every cell.
	typedef struct packed {
		logic                      ins;
		logic signed [COORD_W-1:0] val;
		logic signed [COORD_W-1:0] qx;
		logic        [DIST_W-1:0]  trial;
	} cell_ctrl_t;

	// Returned by every cell.
	typedef struct packed {
		logic gt;
		logic le;
		logic lt;
	} cell_flags_t;

endpackage

>>> hw/rtl/knd_req_if.sv
// ----------------------------------------------------------------------------
// knd_req_if
// Request channel: one load or query word.
// ----------------------------------------------------------------------------
interface knd_req_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic signed [knd_pkg::COORD_W-1:0] coord;
	logic        [knd_pkg::RANK_W-1:0]  rank_k;

	modport source (output valid, output func, output coord, output rank_k, input ready);
	modport sink   (input valid, input func, input coord, input rank_k, output ready);
endinterface

>>> hw/rtl/knd_rsp_if.sv
// ----------------------------------------------------------------------------
// knd_rsp_if
// Response channel: one distance and status word.
// ----------------------------------------------------------------------------
interface knd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [knd_pkg::DIST_W-1:0]   distance;
	logic [knd_pkg::STAT_W-1:0]   status;

	modport source (output valid, output distance, output status, input ready);
	modport sink   (input valid, input distance, input status, output ready);
endinterface

>>> hw/rtl/kth_nearest_distance_query_unit.sv
// ----------------------------------------------------------------------------
// kth_nearest_distance_query_unit
// Sorted point store with k-th nearest distance queries in one dimension.
// ----------------------------------------------------------------------------
// A load word (func 0) inserts coord into a row of MAX_POINTS cells kept in
// ascending order; equal points land after earlier ones. A load into a full
// row leaves it unchanged and answers status 2. A query word (func 1) returns
// the rank_k-th smallest |p - coord| over the stored points, or the farthest
// distance when rank_k exceeds the point count; an empty row or rank_k of
// zero answers status 1. Errors and loads carry distance zero. Flow: one
// word is in flight at a time. A load or an error goes from acceptance
// straight to the done state; a query first runs 32 search steps, one per
// distance bit from the top down. From the done state the word is handed
// to the output register once that is free, and only then is the next
// word taken; a stalled response holds the finished word until the output
// register frees up. Each step has every cell test its point against the
// trial window in parallel; two prefix encoders turn the masks into the
// count inside the window. The output register lets the next word be
// taken while a response waits.
// ----------------------------------------------------------------------------
module kth_nearest_distance_query_unit #(
	parameter int MAX_POINTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	knd_req_if.sink        req,
	knd_rsp_if.source      rsp
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = (CW > knd_pkg::RANK_W) ? CW : knd_pkg::RANK_W;
	localparam int DW = knd_pkg::DIST_W;

	knd_pkg::fsm_state_t state_q, state_d;

	logic [CW-1:0]                     count_q;
	logic signed [knd_pkg::COORD_W-1:0] x_q;
	logic [CW-1:0]                     need_q;
	logic [DW-1:0]                     ans_q;
	logic [knd_pkg::BIT_W-1:0]         bit_q;
	logic [DW-1:0]                     res_dist_q;
	knd_pkg::status_t                  res_stat_q;
	logic                              rsp_vld_q;
	logic [DW-1:0]                     rsp_dist_q;
	knd_pkg::status_t                  rsp_stat_q;

	// FSM decodes
	logic accept;
	logic is_query;
	logic full;
	logic q_err;
	logic last_step;
	logic out_free;
	logic out_load;

	// Search datapath
	logic [DW-1:0] bit_mask;
	logic [DW-1:0] ans_d;
	logic [NW-1:0] rank_ext;
	logic [NW-1:0] count_ext;
	logic [NW-1:0] need_d;
	logic [CW-1:0] le_cnt;
	logic [CW-1:0] lt_cnt;
	logic          enough;

	// Cell row
	knd_pkg::cell_ctrl_t               ctrl;
	knd_pkg::cell_flags_t              flags [MAX_POINTS];
	logic signed [knd_pkg::COORD_W-1:0] pts  [MAX_POINTS];
	logic [MAX_POINTS-1:0]             gt_v;
	logic [MAX_POINTS-1:0]             le_v;
	logic [MAX_POINTS-1:0]             lt_v;

	assign accept   = req.valid && req.ready;
	assign is_query = (req.func == knd_pkg::FUNC_QUERY);
	assign full     = (count_q == CW'(MAX_POINTS));
	assign q_err    = (count_q == '0) || (req.rank_k == '0);
	assign out_free = !rsp_vld_q || rsp.ready;

	// Trial distance: answer so far with every lower bit set.
	assign bit_mask  = DW'(1) << bit_q;
	assign last_step = (bit_q == '0);
	assign enough    = ((le_cnt - lt_cnt) >= need_q);
	assign ans_d     = enough ? ans_q : (ans_q | bit_mask);

	assign rank_ext  = NW'(req.rank_k);
	assign count_ext = NW'(count_q);
	assign need_d    = (rank_ext < count_ext) ? rank_ext : count_ext;

	always_comb begin
		ctrl.ins   = accept && !is_query && !full;
		ctrl.val   = req.coord;
		ctrl.qx    = x_q;
		ctrl.trial = ans_q | (bit_mask - DW'(1));
	end

	// ---- cell row ---------------------------------------------------------
	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		logic                              left_gt;
		logic signed [knd_pkg::COORD_W-1:0] left_pt;

		if (g == 0) begin : g_head
			assign left_gt = 1'b0;
			assign left_pt = pts[g];
		end else begin : g_body
			assign left_gt = flags[g-1].gt;
			assign left_pt = pts[g-1];
		end

		knd_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (CW'(g) < count_q),
			.at_count (CW'(g) == count_q),
			.left_gt  (left_gt),
			.left_pt  (left_pt),
			.pt       (pts[g]),
			.flags    (flags[g])
		);

		assign gt_v[g] = flags[g].gt;
		assign le_v[g] = flags[g].le;
		assign lt_v[g] = flags[g].lt;
	end

	// Points at or below the window top, and points below the window bottom,
	// each form a prefix of the sorted row.
	knd_therm #(.N(MAX_POINTS)) u_therm_le (
		.mask (le_v),
		.cnt  (le_cnt)
	);

	knd_therm #(.N(MAX_POINTS)) u_therm_lt (
		.mask (lt_v),
		.cnt  (lt_cnt)
	);

	// ---- control ----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= knd_pkg::FSM_IDLE;
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			knd_pkg::FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (is_query && !q_err) begin
						state_d = knd_pkg::FSM_SEARCH;
					end else begin
						state_d = knd_pkg::FSM_DONE;
					end
				end
			end
			knd_pkg::FSM_SEARCH: begin
				if (last_step) begin
					state_d = knd_pkg::FSM_DONE;
				end
			end
			knd_pkg::FSM_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = knd_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = knd_pkg::FSM_IDLE;
			end
		endcase
	end

	// ---- datapath registers -----------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= req.coord;
			need_q <= CW'(need_d);
			ans_q  <= '0;
			bit_q  <= knd_pkg::BIT_W'(DW - 1);
			res_dist_q <= '0;
			if (is_query) begin
				res_stat_q <= q_err ? knd_pkg::STAT_EMPTY : knd_pkg::STAT_OK;
			end else begin
				res_stat_q <= full ? knd_pkg::STAT_FULL : knd_pkg::STAT_OK;
			end
		end else if (state_q == knd_pkg::FSM_SEARCH) begin
			ans_q <= ans_d;
			bit_q <= bit_q - knd_pkg::BIT_W'(1);
			if (last_step) begin
				res_dist_q <= ans_d;
			end
		end
		if (out_load) begin
			rsp_dist_q <= res_dist_q;
			rsp_stat_q <= res_stat_q;
		end
	end

	assign rsp.valid    = rsp_vld_q;
	assign rsp.distance = rsp_dist_q;
	assign rsp.status   = rsp_stat_q;

endmodule

>>> hw/rtl/knd_cell.sv
// ----------------------------------------------------------------------------
// knd_cell
// One slot of the sorted point row: holds a point, shifts on insert and
// flags its position against the current query window.
// ----------------------------------------------------------------------------
module knd_cell (
	input  logic                                clk,
	input  knd_pkg::cell_ctrl_t                 ctrl,
	input  logic                                occ,
	input  logic                                at_count,
	input  logic                                left_gt,
	input  logic signed [knd_pkg::COORD_W-1:0]  left_pt,
	output logic signed [knd_pkg::COORD_W-1:0]  pt,
	output knd_pkg::cell_flags_t                flags
);

	logic signed [knd_pkg::COORD_W-1:0] pt_q;
	logic signed [knd_pkg::COORD_W+1:0] diff;
	logic signed [knd_pkg::COORD_W+1:0] dlim;

	assign pt = pt_q;

	always_comb begin
		diff      = (knd_pkg::COORD_W+2)'($signed(pt_q)) - (knd_pkg::COORD_W+2)'($signed(ctrl.qx));
		dlim      = $signed({2'b00, ctrl.trial});
		flags.gt  = occ && (pt_q > ctrl.val);
		flags.le  = occ && (diff <= dlim);
		flags.lt  = occ && (diff < -dlim);
	end

	// Take the left neighbor when it moves right, else take the new point
	// at the first larger slot or at the tail.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_gt) begin
				pt_q <= left_pt;
			end else if (flags.gt || at_count) begin
				pt_q <= ctrl.val;
			end
		end
	end

endmodule

>>> hw/rtl/knd_therm.sv
// ----------------------------------------------------------------------------
// knd_therm
// Thermometer to count: the number of leading ones of a prefix mask.
// ----------------------------------------------------------------------------
module knd_therm #(
	parameter int N = 256
) (
	input  logic [N-1:0]               mask,
	output logic [$clog2(N+1)-1:0]     cnt
);

	localparam int CW = $clog2(N+1);

	logic [N-1:0] brk;

	// The last one of the run marks the count; encode it by OR.
	always_comb begin
		brk = mask & ~(mask >> 1);
		cnt = '0;
		for (int i = 0; i < N; i++) begin
			if (brk[i]) begin
				cnt = cnt | CW'(i + 1);
			end
		end
	end

endmodule

>>> hw/rtl/knd_checker.sv
// ----------------------------------------------------------------------------
// knd_checker
// Port-level checks of the k-th nearest distance query unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module knd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [knd_pkg::DIST_W-1:0]   rsp_distance,
	input logic [knd_pkg::STAT_W-1:0]   rsp_status
);

	// Hold a stalled response.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

	// Only known status codes leave the block.
	`ASSERT_SAME(a_stat_code, clk, arst_n, rsp_valid, rsp_status == knd_pkg::STAT_OK || rsp_status == knd_pkg::STAT_EMPTY || rsp_status == knd_pkg::STAT_FULL, "bad status")

	// Errors carry no distance.
	`ASSERT_SAME(a_err_zero, clk, arst_n, rsp_valid && rsp_status != knd_pkg::STAT_OK, rsp_distance == '0, "error with distance")

	// One word in flight: drop ready right after a word is taken.
	`ASSERT_NEXT(a_one_word, clk, arst_n, req_valid && req_ready, !req_ready, "second word taken")

endmodule

bind kth_nearest_distance_query_unit knd_checker u_knd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_distance (rsp.distance),
	.rsp_status   (rsp.status)
);

>>> tb/kth_nearest_distance_query_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_nearest_distance_query_unit_tb
// Self-checking bench for the k-th nearest distance query unit. A short
// directed list covers empty-store and zero-rank errors, coordinate extremes,
// equal points and ranks above the point count. Random load and query words
// then fill the store past full. Both channels stall at random. Every
// response is checked against a local model of the sorted store.
// ----------------------------------------------------------------------------
module kth_nearest_distance_query_unit_tb;

	localparam int STORE_DEPTH  = 256;
	localparam int RANDOM_WORDS = 1680;
	localparam int QUIET_WORDS  = 150;    // final stretch without any idling
	localparam int LONG_HOLD    = 400;    // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic signed [knd_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [knd_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

	// One directed word. With fixed set, want_dist and stat are the answer as
	// typed here; otherwise the local model supplies it.
	typedef struct packed {
		logic                               func;
		logic signed [knd_pkg::COORD_W-1:0] coord;
		logic        [knd_pkg::RANK_W-1:0]  rank;
		logic                               fixed;
		logic        [knd_pkg::DIST_W-1:0]  want_dist;
		knd_pkg::status_t                   stat;
	} probe_t;

	typedef struct packed {
		logic [knd_pkg::DIST_W-1:0] distance;
		knd_pkg::status_t           status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	knd_req_if req_ch();
	knd_rsp_if rsp_ch();

	kth_nearest_distance_query_unit #(
		.MAX_POINTS(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Local copy of the point store, kept ascending; equal points go last.
	logic signed [knd_pkg::COORD_W-1:0] point_row[$];
	// Answers owed by the block, oldest first.
	answer_t pending_answers[$];

	int  failures     = 0;
	int  cycle_count  = 0;
	bit  quiet        = 1'b0;
	bit  hold_request = 1'b0;
	probe_t probes[$];

	// ------------------------------------------------------------------------
	// Local model
	// ------------------------------------------------------------------------
	function automatic longint span(input logic signed [knd_pkg::COORD_W-1:0] p,
			input logic signed [knd_pkg::COORD_W-1:0] x);
		longint d;
		d = longint'(p) - longint'(x);
		return (d < 0) ? -d : d;
	endfunction

	// Smallest d whose window [x - d, x + d] holds at least need points,
	// found by halving the distance range as the block does.
	function automatic logic [knd_pkg::DIST_W-1:0] nearest_rank_distance(
			input logic signed [knd_pkg::COORD_W-1:0] x, input int unsigned need);
		longint lo, hi, mid, a, b;
		int unsigned hits;
		a  = span(point_row[0], x);
		b  = span(point_row[point_row.size()-1], x);
		lo = 0;
		hi = (a > b) ? a : b;
		while (lo < hi) begin
			mid  = lo + ((hi - lo) >> 1);
			hits = 0;
			foreach (point_row[i])
				if (span(point_row[i], x) <= mid)
					hits++;
			if (hits >= need)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo[knd_pkg::DIST_W-1:0];
	endfunction

	// Apply one accepted word to the local store and return its answer.
	function automatic answer_t predict_answer(input logic f,
			input logic signed [knd_pkg::COORD_W-1:0] c,
			input logic [knd_pkg::RANK_W-1:0] k);
		answer_t     ans;
		int          pos;
		int unsigned need;
		ans.distance = '0;
		ans.status   = knd_pkg::STAT_OK;
		if (f == knd_pkg::FUNC_LOAD) begin
			if (point_row.size() >= STORE_DEPTH) begin
				ans.status = knd_pkg::STAT_FULL;
			end else begin
				pos = point_row.size();
				while (pos > 0 && point_row[pos-1] > c)
					pos--;
				point_row.insert(pos, c);
			end
		end else if (point_row.size() == 0 || k == 0) begin
			ans.status = knd_pkg::STAT_EMPTY;
		end else begin
			need = (int'(k) < point_row.size()) ? int'(k) : point_row.size();
			ans.distance = nearest_rank_distance(c, need);
		end
		return ans;
	endfunction

	// ------------------------------------------------------------------------
	// Random field pickers
	// ------------------------------------------------------------------------
	function automatic logic signed [knd_pkg::COORD_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return COORD_MIN + 1;
			3: return COORD_MAX - 1;
			4: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic logic signed [knd_pkg::COORD_W-1:0] pick_stored();
		return point_row[$urandom_range(0, point_row.size() - 1)];
	endfunction

	function automatic logic signed [knd_pkg::COORD_W-1:0] pick_point();
		case ($urandom_range(0, 5))
			0: return pick_extreme();
			1: return int'($urandom_range(0, 32)) - 16;   // clustered, many ties
			2: return int'($urandom_range(0, 200000)) - 100000;
			3: return (point_row.size() != 0) ? pick_stored() : pick_extreme();
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [knd_pkg::COORD_W-1:0] pick_position();
		case ($urandom_range(0, 5))
			0: return pick_extreme();
			1: return (point_row.size() != 0) ? pick_stored() : 32'sd0;
			2: return (point_row.size() != 0) ?
					pick_stored() + int'($urandom_range(0, 6)) - 3 : 32'sd3;
			3: return int'($urandom_range(0, 40)) - 20;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [knd_pkg::RANK_W-1:0] pick_rank();
		int cnt;
		cnt = point_row.size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 9'd1;
			2: return knd_pkg::RANK_W'((cnt != 0) ? cnt : 1);
			3: return knd_pkg::RANK_W'((cnt < STORE_DEPTH) ? cnt + 1 : STORE_DEPTH);
			4: return knd_pkg::RANK_W'(STORE_DEPTH);
			5: return knd_pkg::RANK_W'($urandom_range(1, 8));
			default: return knd_pkg::RANK_W'($urandom_range(1, (cnt != 0) ? cnt : 1));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request side. Entered just after a falling edge with nothing yet driven
	// in that step; returns the same way.
	// ------------------------------------------------------------------------
	task automatic send_word(input probe_t w);
		int      gap_len;
		answer_t want;
		gap_len = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap_len = $urandom_range(1, 5);
		if (gap_len != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap_len) @(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.func   <= w.func;
		req_ch.coord  <= w.coord;
		req_ch.rank_k <= w.rank;
		// Hold the word until the block takes it.
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		want = predict_answer(w.func, w.coord, w.rank);
		if (w.fixed) begin
			want.distance = w.want_dist;
			want.status   = w.stat;
		end
		pending_answers.push_back(want);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every owed answer is back.
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_answers.size() != 0);
	endtask

	initial begin
		probe_t w;
		int     i;
		req_ch.valid  = 1'b0;
		req_ch.func   = knd_pkg::FUNC_LOAD;
		req_ch.coord  = '0;
		req_ch.rank_k = '0;
		arst_n        = 1'b0;

		// Directed words. Rows with fixed answers are the error codes, the
		// extremes and the cluster loads; the rest go through the local model.
		// Empty store: every query is an error, whatever the rank.
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd0, 9'd1, 1'b1, 32'd0,
			knd_pkg::STAT_EMPTY});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MIN, 9'd256, 1'b1, 32'd0,
			knd_pkg::STAT_EMPTY});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd0, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_EMPTY});
		probes.push_back('{knd_pkg::FUNC_LOAD, COORD_MIN, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		// Widest gap there is: from the top coordinate down to the bottom.
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MAX, 9'd1, 1'b1, 32'hFFFF_FFFF,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MIN, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_EMPTY});
		probes.push_back('{knd_pkg::FUNC_LOAD, COORD_MAX, 9'd511, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MIN, 9'd2, 1'b1, 32'hFFFF_FFFF,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MIN, 9'd1, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		// Rank above the count falls back to the farthest point.
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd0, 9'd256, 1'b1, 32'h8000_0000,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MAX, 9'd256, 1'b1, 32'hFFFF_FFFF,
			knd_pkg::STAT_OK});
		// Equal points and a small cluster around zero.
		probes.push_back('{knd_pkg::FUNC_LOAD, 32'sd0, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_LOAD, 32'sd0, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_LOAD, -32'sd1, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_LOAD, 32'sd7, 9'd0, 1'b1, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd0, 9'd1, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd0, 9'd3, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd3, 9'd2, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, -32'sd1, 9'd4, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sd4, 9'd6, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, COORD_MAX - 1, 9'd7, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		// Alternating bit patterns in the coordinate.
		probes.push_back('{knd_pkg::FUNC_LOAD, 32'sh5555_5555, 9'd0, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_LOAD, 32'shAAAA_AAAA, 9'd0, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, 32'sh2AAA_AAAA, 9'd256, 1'b0, 32'd0,
			knd_pkg::STAT_OK});
		probes.push_back('{knd_pkg::FUNC_QUERY, -32'sd3, 9'd5, 1'b0, 32'd0,
			knd_pkg::STAT_OK});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (probes[j])
			send_word(probes[j]);

		// Random words. Loads run at about a third, so the store fills a bit
		// before halfway and the rest of the run sees full-store loads.
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300)
				hold_request = 1'b1;     // receiver stalls long; input backs up
			if (i == 700 || i == 1250)
				pause_until_drained();
			if (i == RANDOM_WORDS - QUIET_WORDS)
				quiet = 1'b1;
			w.fixed     = 1'b0;
			w.want_dist = '0;
			w.stat      = knd_pkg::STAT_OK;
			if ($urandom_range(0, 99) < 35) begin
				w.func  = knd_pkg::FUNC_LOAD;
				w.coord = pick_point();
				w.rank  = knd_pkg::RANK_W'($urandom_range(0, STORE_DEPTH)); // ignored by loads
			end else begin
				w.func  = knd_pkg::FUNC_QUERY;
				w.coord = pick_position();
				w.rank  = pick_rank();
			end
			send_word(w);
		end
		req_ch.valid <= 1'b0;

		// Wait out every owed answer, then watch for strays.
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$error("%0d answers never arrived", pending_answers.size());
			failures++;
		end
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Response side: random stall bursts, plus one long hold-off on request.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: compare each response word with the oldest owed answer.
	// ------------------------------------------------------------------------
	answer_t head;

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected response: distance %0d status %0d",
					rsp_ch.distance, rsp_ch.status);
				failures++;
			end else begin
				head = pending_answers.pop_front();
				if (rsp_ch.distance !== head.distance) begin
					$error("distance: expected %0d, got %0d",
						head.distance, rsp_ch.distance);
					failures++;
				end
				if (rsp_ch.status !== head.status) begin
					$error("status: expected %0d, got %0d",
						head.status, rsp_ch.status);
					failures++;
				end
			end
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
